[src/wavetable_lfo_with_fade_in_defines.svh]
// Assertion macros used by the wavetable LFO top level
`ifndef WAVETABLE_LFO_WITH_FADE_IN_DEFINES_SVH
`define WAVETABLE_LFO_WITH_FADE_IN_DEFINES_SVH

// Check an expression at every rising clock edge outside reset
`define WTLFO_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition is followed by another in the next cycle
`define WTLFO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/wtlfo_pkg.sv]
// Types and constants of the wavetable LFO
package wtlfo_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_INTERP,
        ST_MAP
    } state_t;

    typedef enum logic [1:0] {
        FUNC_TICK,
        FUNC_NOTE_ON,
        FUNC_NOTE_OFF,
        FUNC_ALL_OFF
    } func_t;

    typedef enum logic [2:0] {
        REG_PHASE_INC,
        REG_WAVEFORM,
        REG_PHASE_OFFSET,
        REG_FADE_BASE,
        REG_FADE_COEF,
        REG_FADE_ENABLED,
        REG_OUTPUT_MODE,
        REG_NOTE_FLAGS
    } cfg_reg_t;

    localparam logic [2:0] WAVE_SINE     = 3'd0;
    localparam logic [2:0] WAVE_TRIANGLE = 3'd1;
    localparam logic [2:0] WAVE_SAW      = 3'd2;
    localparam logic [2:0] WAVE_SQUARE   = 3'd3;
    localparam logic [2:0] WAVE_RANDOM   = 3'd4;

    localparam logic [2:0] MODE_GAIN       = 3'd0;
    localparam logic [2:0] MODE_GLOBAL_UNI = 3'd1;
    localparam logic [2:0] MODE_GLOBAL_BI  = 3'd2;
    localparam logic [2:0] MODE_PITCH_UNI  = 3'd3;
    localparam logic [2:0] MODE_PITCH_BI   = 3'd4;

    localparam int NOTE_LEGATO_BIT = 0;
    localparam int NOTE_IGNORE_BIT = 1;

    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam longint      ONE_Q30_L   = 64'sd1073741824;

endpackage

[src/wavetable_lfo_with_fade_in.sv]
// Top level of the wavetable LFO with exponential fade-in
//
// Usage:
//   s_axis carries one event word: tuser is the function (tick, note on, note off,
//   all notes off), tdata the random sample for random-hold mode.
//   m_axis returns one word per tick: lfo_value in tdata, the cycle wrap flag in
//   tuser. Note events update the key count and phase state and return nothing.
//   cfg writes one register per word (index, data); write only while idle.
// Timing:
//   A tick is accepted in the idle state and runs its steps (accept, read of the
//   second ROM entry with fade update, interpolation, output mapping); one
//   multiplier serves the three multiply steps and the quarter-wave sine ROM has
//   one registered read port. A note event is handled without leaving the idle state.
//   Rate: one note event every cycle while idle; ticks never overlap.
// Reset:
//   Asynchronous and active low; state, settings, phase, fade, key count, held
//   random and output valid reset at once, no clearing pass; the rest is not.
// Stall:
//   The output register holds a result while the sink stalls; the next event is
//   still taken, and a second tick waits in its last step until the word is taken.
`include "wavetable_lfo_with_fade_in_defines.svh"

module wavetable_lfo_with_fade_in #(
    parameter int TABLE_SIZE = 512,
    parameter int FRAC_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] random_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [16:0] lfo_value, [23:17] zero
    output logic        m_axis_tuser,   // [0] cycle_wrapped
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [24:0] cfg_data
);
    import wtlfo_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_SIZE);
    localparam int PHASE_W = IDX_W + FRAC_BITS;
    localparam int SUM_W   = ((PHASE_W > 25) ? PHASE_W : 25) + 1;
    localparam int OFF_W   = 16 + PHASE_W;
    localparam int QTR     = TABLE_SIZE / 4;
    localparam int QA_W    = $clog2(QTR + 1);
    localparam int MB      = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
    localparam int MP      = MB + 18;
    localparam int IW      = FRAC_BITS + 20;
    localparam int TRI_SH  = 17 - IDX_W;

    localparam logic [IDX_W-1:0] HALF_I = IDX_W'(TABLE_SIZE / 2);
    localparam logic [IDX_W:0]   QTR_E  = (IDX_W + 1)'(QTR);
    localparam logic [IDX_W:0]   Q2_E   = (IDX_W + 1)'(2 * QTR);
    localparam logic [IDX_W:0]   Q3_E   = (IDX_W + 1)'(3 * QTR);
    localparam logic [IDX_W:0]   TS_E   = (IDX_W + 1)'(TABLE_SIZE);

    // quarter-wave sine ROM: {entry on the upper half, entry on the lower half}
    logic [33:0] sine_qrom [QTR+1];

    for (genvar j = 0; j <= QTR; j++) begin : g_qrom
        localparam logic [63:0] TH = (PI_HALF_Q30 * 64'(j) + 64'(QTR / 2)) / 64'(QTR);
        localparam logic [63:0] X2 = (TH * TH) >> 30;
        localparam logic [63:0] T1 = ((ONE_Q30 * X2) >> 30) / 64'd2;
        localparam logic [63:0] T2 = ((T1 * X2) >> 30) / 64'd12;
        localparam logic [63:0] T3 = ((T2 * X2) >> 30) / 64'd30;
        localparam logic [63:0] T4 = ((T3 * X2) >> 30) / 64'd56;
        localparam logic [63:0] T5 = ((T4 * X2) >> 30) / 64'd90;
        localparam logic [63:0] T6 = ((T5 * X2) >> 30) / 64'd132;
        localparam logic [63:0] T7 = ((T6 * X2) >> 30) / 64'd182;
        localparam longint ACC = ONE_Q30_L - longint'(T1) + longint'(T2) - longint'(T3)
                                 + longint'(T4) - longint'(T5) + longint'(T6)
                                 - longint'(T7);
        localparam longint CC = (ACC < 0) ? 64'sd0 : ((ACC > ONE_Q30_L) ? ONE_Q30_L : ACC);
        localparam logic [16:0] PLUS  = 17'((ONE_Q30 + 64'(CC) + 64'd16384) >> 15);
        localparam logic [16:0] MINUS = 17'((ONE_Q30 - 64'(CC) + 64'd16384) >> 15);
        assign sine_qrom[j] = {PLUS, MINUS};
    end

    function automatic logic [QA_W-1:0] qrom_addr(input logic [IDX_W-1:0] i);
        logic [IDX_W:0] ie;
        logic [IDX_W:0] jj;
        ie = {1'b0, i};
        if (ie <= QTR_E) begin
            jj = ie;
        end
        else if (ie <= Q2_E) begin
            jj = Q2_E - ie;
        end
        else if (ie <= Q3_E) begin
            jj = ie - Q2_E;
        end
        else begin
            jj = TS_E - ie;
        end
        return jj[QA_W-1:0];
    endfunction

    function automatic logic [16:0] wave_value(input logic [2:0] w,
                                               input logic [IDX_W-1:0] i,
                                               input logic [33:0] qword);
        logic [IDX_W:0] ie;
        logic [16:0]    ramp;
        logic [16:0]    v;
        ie   = {1'b0, i};
        ramp = 17'(i) << TRI_SH;
        case (w)
            WAVE_TRIANGLE: v = (i >= HALF_I) ? (ramp - ONE_Q16) : (ONE_Q16 - ramp);
            WAVE_SAW:      v = ramp >> 1;
            WAVE_SQUARE:   v = (i >= HALF_I) ? 17'd0 : ONE_Q16;
            default:       v = ((ie > QTR_E) && (ie <= Q3_E)) ? qword[16:0] : qword[33:17];
        endcase
        return v;
    endfunction

    state_t state_reg, state_next;

    logic [24:0]        phase_inc_reg;
    logic [2:0]         waveform_reg;
    logic [15:0]        phase_offset_reg;
    logic [16:0]        fade_base_reg;
    logic [16:0]        fade_coef_reg;
    logic               fade_enabled_reg;
    logic [2:0]         output_mode_reg;
    logic [1:0]         note_flags_reg;

    logic [PHASE_W-1:0] phase_acc_reg, phase_acc_next;
    logic [PHASE_W-1:0] next_phase_reg, next_phase_next;
    logic               wrap_reg, wrap_next;
    logic [16:0]        held_random_reg, held_random_next;
    logic [16:0]        fade_level_reg, fade_level_next;
    logic [7:0]         keys_held_reg, keys_held_next;
    logic [15:0]        rnd_reg, rnd_next;
    logic [16:0]        v1_reg, v1_next;
    logic [16:0]        raw_reg, raw_next;
    logic [33:0]        rom_data_reg;
    logic               out_valid_reg, out_valid_next;
    logic [16:0]        out_value_reg, out_value_next;
    logic               out_wrap_reg, out_wrap_next;

    logic                  in_accept;
    logic                  out_free;
    logic [IDX_W-1:0]      idx;
    logic [IDX_W-1:0]      idx_p1;
    logic [FRAC_BITS-1:0]  frac;
    logic [QA_W-1:0]       rom_addr;
    logic signed [17:0]    mul_a;
    logic signed [MB-1:0]  mul_b;
    logic signed [MP-1:0]  mul_p;
    logic [SUM_W-1:0]      phase_sum;
    logic [OFF_W-1:0]      offset_ext;
    logic [16:0]           v2;
    logic [IW-1:0]         interp_sum;
    logic [17:0]           interp;
    logic [17:0]           fade_sum;
    logic [34:0]           map_sum;
    logic [34:0]           map_val;
    logic [16:0]           lfo_val;
    logic                  restart_ok;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign idx       = phase_acc_reg[PHASE_W-1:FRAC_BITS];
    assign idx_p1    = idx + 1'b1;
    assign frac      = phase_acc_reg[FRAC_BITS-1:0];
    assign mul_p     = MP'(mul_a) * MP'(mul_b);

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_value_reg};
    assign m_axis_tuser  = out_wrap_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (func_t'(s_axis_tuser) == FUNC_TICK))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:   state_next = ST_INTERP;
            ST_INTERP: state_next = ST_MAP;
            ST_MAP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // handshake, ROM address and multiplier operands
    always_comb
    begin
        s_axis_tready = 1'b0;
        rom_addr      = qrom_addr(idx_p1);
        mul_a         = 18'sd0;
        mul_b         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                rom_addr      = qrom_addr(idx);
            end
            ST_READ:
            begin
                mul_a = $signed({1'b0, fade_level_reg});
                mul_b = $signed(MB'(fade_coef_reg));
            end
            ST_INTERP:
            begin
                mul_a = $signed({1'b0, v2}) - $signed({1'b0, v1_reg});
                mul_b = $signed(MB'(frac));
            end
            ST_MAP:
            begin
                mul_a = $signed({1'b0, raw_reg});
                mul_b = $signed(MB'(fade_level_reg));
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        phase_sum  = SUM_W'(phase_acc_reg) + SUM_W'(phase_inc_reg);
        offset_ext = {phase_offset_reg, {PHASE_W{1'b0}}};
        restart_ok = (!note_flags_reg[NOTE_LEGATO_BIT] || (keys_held_reg == 8'd0))
                     && !note_flags_reg[NOTE_IGNORE_BIT];
        v2         = wave_value(waveform_reg, idx_p1, rom_data_reg);
        interp_sum = (IW'(v1_reg) << FRAC_BITS) + IW'(mul_p)
                     + (IW'(1) << (FRAC_BITS - 1));
        interp     = interp_sum[FRAC_BITS+17:FRAC_BITS];
        if (interp > 18'(ONE_Q16))
        begin
            interp = 18'(ONE_Q16);
        end
        fade_sum = 18'(fade_base_reg) + 18'((35'(mul_p[33:0]) + 35'd32768) >> 16);
        map_sum  = 35'(mul_p[33:0]) + 35'd32768;
        case (output_mode_reg)
            MODE_GLOBAL_BI, MODE_PITCH_BI:
                map_val = ((35'(ONE_Q16 - fade_level_reg) << 15) + map_sum) >> 16;
            MODE_PITCH_UNI:
                map_val = map_sum >> 16;
            default:
                map_val = 35'(ONE_Q16) - (map_sum >> 16);
        endcase
        lfo_val = (map_val > 35'(ONE_Q16)) ? ONE_Q16 : map_val[16:0];

        phase_acc_next   = phase_acc_reg;
        next_phase_next  = next_phase_reg;
        wrap_next        = wrap_reg;
        held_random_next = held_random_reg;
        fade_level_next  = fade_level_reg;
        keys_held_next   = keys_held_reg;
        rnd_next         = rnd_reg;
        v1_next          = v1_reg;
        raw_next         = raw_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_value_next   = out_value_reg;
        out_wrap_next    = out_wrap_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (func_t'(s_axis_tuser))
                        FUNC_TICK:
                        begin
                            next_phase_next = phase_sum[PHASE_W-1:0];
                            wrap_next       = |phase_sum[SUM_W-1:PHASE_W];
                            rnd_next        = s_axis_tdata;
                        end
                        FUNC_NOTE_ON:
                        begin
                            if (restart_ok)
                            begin
                                phase_acc_next  = offset_ext[OFF_W-1:16];
                                fade_level_next = 17'd0;
                            end
                            if (keys_held_reg != 8'hFF)
                            begin
                                keys_held_next = keys_held_reg + 8'd1;
                            end
                        end
                        FUNC_NOTE_OFF:
                        begin
                            if (keys_held_reg != 8'd0)
                            begin
                                keys_held_next = keys_held_reg - 8'd1;
                            end
                        end
                        default:
                        begin
                            keys_held_next = 8'd0;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                v1_next = wave_value(waveform_reg, idx, rom_data_reg);
                if (fade_enabled_reg || (fade_level_reg < ONE_Q16))
                begin
                    fade_level_next = (fade_sum > 18'(ONE_Q16)) ? ONE_Q16 : fade_sum[16:0];
                end
                else
                begin
                    fade_level_next = ONE_Q16;
                end
            end
            ST_INTERP:
            begin
                if (waveform_reg == WAVE_RANDOM)
                begin
                    if (wrap_reg)
                    begin
                        held_random_next = {1'b0, rnd_reg};
                        raw_next         = {1'b0, rnd_reg};
                    end
                    else
                    begin
                        raw_next = held_random_reg;
                    end
                end
                else
                begin
                    raw_next = 17'(18'(ONE_Q16) - interp);
                end
            end
            ST_MAP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = lfo_val;
                    out_wrap_next  = wrap_reg;
                    phase_acc_next = next_phase_reg;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !m_axis_tready;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rom_data_reg   <= sine_qrom[rom_addr];
        next_phase_reg <= next_phase_next;
        wrap_reg       <= wrap_next;
        rnd_reg        <= rnd_next;
        v1_reg         <= v1_next;
        raw_reg        <= raw_next;
        out_value_reg  <= out_value_next;
        out_wrap_reg   <= out_wrap_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            phase_acc_reg    <= '0;
            held_random_reg  <= ONE_Q16;
            fade_level_reg   <= 17'd0;
            keys_held_reg    <= 8'd0;
            out_valid_reg    <= 1'b0;
            phase_inc_reg    <= 25'd0;
            waveform_reg     <= WAVE_SINE;
            phase_offset_reg <= 16'd0;
            fade_base_reg    <= 17'd0;
            fade_coef_reg    <= 17'd0;
            fade_enabled_reg <= 1'b1;
            output_mode_reg  <= MODE_GAIN;
            note_flags_reg   <= 2'd1;
        end
        else
        begin
            state_reg       <= state_next;
            phase_acc_reg   <= phase_acc_next;
            held_random_reg <= held_random_next;
            fade_level_reg  <= fade_level_next;
            keys_held_reg   <= keys_held_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_PHASE_INC:    phase_inc_reg    <= cfg_data;
                    REG_WAVEFORM:     waveform_reg     <= cfg_data[2:0];
                    REG_PHASE_OFFSET: phase_offset_reg <= cfg_data[15:0];
                    REG_FADE_BASE:    fade_base_reg    <= cfg_data[16:0];
                    REG_FADE_COEF:    fade_coef_reg    <= cfg_data[16:0];
                    REG_FADE_ENABLED: fade_enabled_reg <= cfg_data[0];
                    REG_OUTPUT_MODE:  output_mode_reg  <= cfg_data[2:0];
                    REG_NOTE_FLAGS:   note_flags_reg   <= cfg_data[1:0];
                    default:          phase_inc_reg    <= phase_inc_reg;
                endcase
            end
        end
    end

    `WTLFO_ASSERT_ALWAYS(a_fade_in_range, fade_level_reg <= ONE_Q16, "fade level above one")
    `WTLFO_ASSERT_ALWAYS(a_random_in_range, held_random_reg <= ONE_Q16, "held random above one")
    `WTLFO_ASSERT_NEXT(a_note_one_cycle, in_accept && (s_axis_tuser != FUNC_TICK), state_reg == ST_IDLE, "note event left idle")
    `WTLFO_ASSERT_NEXT(a_map_waits, (state_reg == ST_MAP) && !out_free, (state_reg == ST_MAP) && out_valid_reg, "result dropped while sink stalled")

endmodule
